@@ design/ocs_arbitrary_axis_transform_top_defines.svh @@
// Assertion macros shared by the object coordinate transform modules.
`ifndef OCS_ARBITRARY_AXIS_TRANSFORM_TOP_DEFINES_SVH
`define OCS_ARBITRARY_AXIS_TRANSFORM_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define OCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define OCS_ASSERT_IMPL(lbl, ante, cons, msg) `OCS_ASSERT(lbl, ante |-> cons, msg)
`else
`define OCS_ASSERT(lbl, prop, msg)
`define OCS_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

@@ design/ocs_aat_pkg.sv @@
// Types, constants and helper functions of the object coordinate transform.
package ocs_aat_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 32;
  localparam int NORM_LAT   = 8 + SQRT_STEPS + DIV_STEPS;
  localparam int PIPE_LAT   = 7 + 3 * NORM_LAT;
  localparam int KK_DEPTH   = NORM_LAT - 4;

  localparam logic [31:0]        ONE_Q16     = 32'h0001_0000;
  localparam logic [31:0]        NEG_ONE_Q16 = 32'hFFFF_0000;
  localparam logic [31:0]        Q30_ONE     = 32'h4000_0000;
  localparam logic signed [31:0] AXIS_TH     = 32'sh0100_0000;

  typedef struct packed {
    logic        two_d;
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [31:0] point_z;
    logic [31:0] normal_x;
    logic [31:0] normal_y;
    logic [31:0] normal_z;
  } in_t;

  typedef struct packed {
    logic [31:0] result_x;
    logic [31:0] result_y;
    logic [31:0] result_z;
  } out_t;

  typedef logic [2:0][31:0] vec32_t;
  typedef logic [2:0][63:0] vec64_t;

  // Everything an item carries alongside the normalizer pipelines.
  typedef struct packed {
    logic        pass;
    logic        negx;
    logic        td;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    vec32_t      az;
    vec32_t      ax;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [2:0][30:0] m;
    logic [2:0]       neg;
    logic             zero;
  } kk_t;

  function automatic logic [63:0] sext64(input logic [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

  function automatic logic [63:0] mul32s(input logic [31:0] a, input logic [31:0] b);
    logic signed [63:0] ea;
    logic signed [63:0] eb;
    ea = $signed(sext64(a));
    eb = $signed(sext64(b));
    return 64'(ea * eb);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    logic [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -36'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ design/ocs_aat_norm.sv @@
// Pipelined normalizer: signed vector in, signed Q2.30 unit vector out.
`include "ocs_arbitrary_axis_transform_top_defines.svh"
module ocs_aat_norm import ocs_aat_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  vec64_t in_vec,
  input  side_t  in_side,
  output logic   out_valid,
  output vec32_t out_vec,
  output side_t  out_side
);

  logic [NORM_LAT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NORM_LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[NORM_LAT-1];

  // Magnitudes and their union, whose top bit is the top bit of the largest.
  logic [2:0][61:0] mag1_nxt, mag1_r, mag2_r, mag3_r;
  logic [2:0]       neg1_nxt, neg1_r, neg2_r, neg3_r;
  logic [61:0]      or1_nxt, or1_r;
  side_t            side1_r, side2_r, side3_r;

  always_comb begin
    logic [63:0] a;
    or1_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      neg1_nxt[i] = in_vec[i][63];
      a = neg1_nxt[i] ? (64'd0 - in_vec[i]) : in_vec[i];
      mag1_nxt[i] = a[61:0];
      or1_nxt = or1_nxt | a[61:0];
    end
  end

  // Leading one: byte first, then bit within the byte.
  logic [63:0] pad1;
  logic [2:0]  grp2_nxt, grp2_r;
  logic [7:0]  byte2_nxt, byte2_r;
  logic        nz2_nxt, nz2_r;

  assign pad1 = {2'b00, or1_r};

  always_comb begin
    grp2_nxt = '0;
    byte2_nxt = '0;
    nz2_nxt = 1'b0;
    for (int g = 0; g < 8; g++) begin
      if (pad1[g*8 +: 8] != 8'd0) begin
        grp2_nxt = 3'(g);
        byte2_nxt = pad1[g*8 +: 8];
        nz2_nxt = 1'b1;
      end
    end
  end

  logic [5:0] pos3_nxt, pos3_r;
  logic       zero3_r;

  always_comb begin
    logic [2:0] lo;
    lo = '0;
    for (int b = 0; b < 8; b++) begin
      if (byte2_r[b]) begin
        lo = 3'(b);
      end
    end
    pos3_nxt = {grp2_r, lo};
  end

  // Align so that the largest magnitude lies in [2^30, 2^31).
  kk_t kk0_nxt;
  kk_t kk_r [0:KK_DEPTH-1];

  always_comb begin
    logic [61:0] t;
    kk0_nxt.side = side3_r;
    kk0_nxt.neg  = neg3_r;
    kk0_nxt.zero = zero3_r;
    for (int i = 0; i < 3; i++) begin
      if (pos3_r >= 6'd30) begin
        t = mag3_r[i] >> 6'(pos3_r - 6'd30);
      end else begin
        t = mag3_r[i] << 6'(6'd30 - pos3_r);
      end
      kk0_nxt.m[i] = t[30:0];
    end
  end

  always_ff @(posedge clk) begin
    mag1_r   <= mag1_nxt;
    neg1_r   <= neg1_nxt;
    or1_r    <= or1_nxt;
    side1_r  <= in_side;
    mag2_r   <= mag1_r;
    neg2_r   <= neg1_r;
    side2_r  <= side1_r;
    grp2_r   <= grp2_nxt;
    byte2_r  <= byte2_nxt;
    nz2_r    <= nz2_nxt;
    mag3_r   <= mag2_r;
    neg3_r   <= neg2_r;
    side3_r  <= side2_r;
    pos3_r   <= pos3_nxt;
    zero3_r  <= !nz2_r;
    kk_r[0]  <= kk0_nxt;
    for (int i = 1; i < KK_DEPTH; i++) begin
      kk_r[i] <= kk_r[i-1];
    end
  end

  // Sum of squares.
  logic [2:0][61:0] sq5_r;
  logic [64:0]      rem_r  [0:SQRT_STEPS-1];
  logic [31:0]      root_r [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq5_r[i] <= 62'(kk_r[0].m[i]) * 62'(kk_r[0].m[i]);
    end
    rem_r[0]  <= 65'(sq5_r[0]) + 65'(sq5_r[1]) + 65'(sq5_r[2]);
    root_r[0] <= '0;
  end

  // Square root, one result bit per stage.
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam int K = SQRT_STEPS - 1 - j;
    logic [65:0] trial;
    logic        take;
    assign trial = (66'(root_r[j]) << (K + 1)) + (66'd1 << (2 * K));
    assign take  = 66'(rem_r[j]) >= trial;
    always_ff @(posedge clk) begin
      root_r[j+1] <= take ? (root_r[j] | (32'd1 << K)) : root_r[j];
    end
    if (j < SQRT_STEPS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem_r[j+1] <= take ? 65'(66'(rem_r[j]) - trial) : rem_r[j];
      end
    end
  end

  // Rounded quotient mag * 2^30 / l, one bit per stage in three lanes.
  logic [2:0][61:0] dn_r [0:DIV_STEPS-1];
  logic [31:0]      dd_r [0:DIV_STEPS-1];
  logic [2:0][31:0] dr_r [0:DIV_STEPS-1];
  logic [2:0][31:0] dq_r [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    logic [61:0] n;
    dd_r[0] <= root_r[SQRT_STEPS];
    for (int i = 0; i < 3; i++) begin
      n = (62'(kk_r[SQRT_STEPS + 2].m[i]) << 30) + 62'(root_r[SQRT_STEPS][31:1]);
      dn_r[0][i] <= n;
      dr_r[0][i] <= {2'b00, n[61:32]};
      dq_r[0][i] <= '0;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [2:0][32:0] tr;
    logic [2:0]       qb;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        tr[i] = {dr_r[j][i], dn_r[j][i][DIV_STEPS-1-j]};
        qb[i] = tr[i] >= {1'b0, dd_r[j]};
      end
    end
    always_ff @(posedge clk) begin
      for (int i = 0; i < 3; i++) begin
        dq_r[j+1][i] <= {dq_r[j][i][30:0], qb[i]};
      end
    end
    if (j < DIV_STEPS - 1) begin : g_pass
      always_ff @(posedge clk) begin
        dn_r[j+1] <= dn_r[j];
        dd_r[j+1] <= dd_r[j];
        for (int i = 0; i < 3; i++) begin
          dr_r[j+1][i] <= qb[i] ? 32'(tr[i] - {1'b0, dd_r[j]}) : tr[i][31:0];
        end
      end
    end
  end

  // Clamp to one, restore signs, and force zero for a zero vector.
  vec32_t out_vec_nxt;

  always_comb begin
    logic [31:0] q;
    for (int i = 0; i < 3; i++) begin
      q = (dq_r[DIV_STEPS][i] > Q30_ONE) ? Q30_ONE : dq_r[DIV_STEPS][i];
      if (kk_r[KK_DEPTH-1].zero) begin
        out_vec_nxt[i] = '0;
      end else if (kk_r[KK_DEPTH-1].neg[i]) begin
        out_vec_nxt[i] = 32'd0 - q;
      end else begin
        out_vec_nxt[i] = q;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_vec  <= out_vec_nxt;
    out_side <= kk_r[KK_DEPTH-1].side;
  end

  `OCS_ASSERT_IMPL(a_norm_lat, in_valid, ##NORM_LAT out_valid, "normalizer lost a beat")
  `OCS_ASSERT_IMPL(a_norm_unit, out_valid,
    ($signed(out_vec[0]) <= $signed(Q30_ONE)) && ($signed(out_vec[0]) >= -$signed(Q30_ONE)) &&
    ($signed(out_vec[1]) <= $signed(Q30_ONE)) && ($signed(out_vec[1]) >= -$signed(Q30_ONE)) &&
    ($signed(out_vec[2]) <= $signed(Q30_ONE)) && ($signed(out_vec[2]) >= -$signed(Q30_ONE)),
    "unit component above one")
  `OCS_ASSERT_IMPL(a_norm_zero, out_valid && $past(in_valid && (in_vec == '0), NORM_LAT),
    out_vec == '0, "zero vector did not normalize to zero")

endmodule

@@ design/ocs_arbitrary_axis_transform_top.sv @@
// Throughput: one beat per clock cycle; busy is low whenever reset is released.
// The rate is set by the fully pipelined normalizers, each 72 stages deep
// (one square root bit and one quotient bit per stage).
// Reset (synchronous, active low) empties the pipeline; beats in flight are dropped.
// Results appear for one cycle on out_valid and cannot be held off.
`include "ocs_arbitrary_axis_transform_top_defines.svh"
module ocs_arbitrary_axis_transform_top import ocs_aat_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  // The pipeline never stalls, so the only time no beat is taken is reset.
  assign busy = ~rst_n;

  logic acc;
  assign acc = start && !busy;

  // Entry stage: detect the special extrusions and zero z in planar mode.
  side_t  t0_side_nxt, t0_side_r;
  vec64_t t0_vec_r;
  logic   t0_v_r;

  always_comb begin
    logic exy0;
    exy0 = (in_data.normal_x == 32'd0) && (in_data.normal_y == 32'd0);
    t0_side_nxt      = '0;
    t0_side_nxt.td   = in_data.two_d;
    t0_side_nxt.pass = exy0 && ((in_data.normal_z == ONE_Q16) ||
                                (in_data.two_d && (in_data.normal_z == 32'd0)));
    t0_side_nxt.negx = exy0 && (in_data.normal_z == NEG_ONE_Q16);
    t0_side_nxt.px   = in_data.point_x;
    t0_side_nxt.py   = in_data.point_y;
    t0_side_nxt.pz   = in_data.two_d ? 32'd0 : in_data.point_z;
  end

  always_ff @(posedge clk) begin
    t0_side_r   <= t0_side_nxt;
    t0_vec_r[0] <= sext64(in_data.normal_x);
    t0_vec_r[1] <= sext64(in_data.normal_y);
    t0_vec_r[2] <= sext64(in_data.normal_z);
  end

  // First normalizer gives the z axis.
  logic   n1_v, n2_v, n3_v;
  vec32_t n1_u, n2_u, n3_u;
  side_t  n1_side, n2_side, n3_side;

  ocs_aat_norm u_norm_z (
    .clk(clk), .rst_n(rst_n),
    .in_valid(t0_v_r), .in_vec(t0_vec_r), .in_side(t0_side_r),
    .out_valid(n1_v), .out_vec(n1_u), .out_side(n1_side)
  );

  // Helper axis: world Y when the axis is nearly along Z, else world Z.
  // The cross product with the helper is written out directly.
  vec64_t h_vec_nxt, h_vec_r;
  side_t  h_side_nxt, h_side_r;
  logic   h_v_r;

  always_comb begin
    logic signed [31:0] a0;
    logic signed [31:0] a1;
    logic               near_z;
    a0 = $signed(n1_u[0]);
    a1 = $signed(n1_u[1]);
    near_z = (a0 < AXIS_TH) && (a0 > -AXIS_TH) && (a1 < AXIS_TH) && (a1 > -AXIS_TH);
    if (near_z) begin
      h_vec_nxt[0] = sext64(n1_u[2]);
      h_vec_nxt[1] = '0;
      h_vec_nxt[2] = 64'd0 - sext64(n1_u[0]);
    end else begin
      h_vec_nxt[0] = 64'd0 - sext64(n1_u[1]);
      h_vec_nxt[1] = sext64(n1_u[0]);
      h_vec_nxt[2] = '0;
    end
  end

  // The z axis joins the side data here.
  always_comb begin
    h_side_nxt    = n1_side;
    h_side_nxt.az = n1_u;
  end

  always_ff @(posedge clk) begin
    h_vec_r  <= h_vec_nxt;
    h_side_r <= h_side_nxt;
  end

  // Second normalizer gives the x axis.
  ocs_aat_norm u_norm_x (
    .clk(clk), .rst_n(rst_n),
    .in_valid(h_v_r), .in_vec(h_vec_r), .in_side(h_side_r),
    .out_valid(n2_v), .out_vec(n2_u), .out_side(n2_side)
  );

  // y = z cross x at full Q4.60 precision: products, then differences.
  logic [5:0][63:0] x1_p_r;
  side_t            x1_side_nxt, x1_side_r, x2_side_r;
  vec64_t           x2_vec_r;
  logic             x1_v_r, x2_v_r;

  // The x axis joins the side data here.
  always_comb begin
    x1_side_nxt    = n2_side;
    x1_side_nxt.ax = n2_u;
  end

  always_ff @(posedge clk) begin
    x1_p_r[0]    <= mul32s(n2_side.az[1], n2_u[2]);
    x1_p_r[1]    <= mul32s(n2_side.az[2], n2_u[1]);
    x1_p_r[2]    <= mul32s(n2_side.az[2], n2_u[0]);
    x1_p_r[3]    <= mul32s(n2_side.az[0], n2_u[2]);
    x1_p_r[4]    <= mul32s(n2_side.az[0], n2_u[1]);
    x1_p_r[5]    <= mul32s(n2_side.az[1], n2_u[0]);
    x1_side_r    <= x1_side_nxt;
    x2_vec_r[0]  <= x1_p_r[0] - x1_p_r[1];
    x2_vec_r[1]  <= x1_p_r[2] - x1_p_r[3];
    x2_vec_r[2]  <= x1_p_r[4] - x1_p_r[5];
    x2_side_r    <= x1_side_r;
  end

  // Third normalizer gives the y axis.
  ocs_aat_norm u_norm_y (
    .clk(clk), .rst_n(rst_n),
    .in_valid(x2_v_r), .in_vec(x2_vec_r), .in_side(x2_side_r),
    .out_valid(n3_v), .out_vec(n3_u), .out_side(n3_side)
  );

  // Projection: nine products, then rounded sums, then saturation and the
  // choice between the general result and the pass-through cases.
  logic [8:0][63:0] p1_r;
  side_t            p1_side_r, p2_side_r;
  logic [2:0][35:0] p2_r;
  logic             p1_v_r, p2_v_r;

  always_ff @(posedge clk) begin
    p1_r[0]   <= mul32s(n3_side.px, n3_side.ax[0]);
    p1_r[1]   <= mul32s(n3_side.py, n3_side.ax[1]);
    p1_r[2]   <= mul32s(n3_side.pz, n3_side.ax[2]);
    p1_r[3]   <= mul32s(n3_side.px, n3_u[0]);
    p1_r[4]   <= mul32s(n3_side.py, n3_u[1]);
    p1_r[5]   <= mul32s(n3_side.pz, n3_u[2]);
    p1_r[6]   <= mul32s(n3_side.px, n3_side.az[0]);
    p1_r[7]   <= mul32s(n3_side.py, n3_side.az[1]);
    p1_r[8]   <= mul32s(n3_side.pz, n3_side.az[2]);
    p1_side_r <= n3_side;
    p2_side_r <= p1_side_r;
  end

  // Adding half and shifting arithmetically rounds half toward plus infinity.
  always_ff @(posedge clk) begin
    logic [65:0] s;
    for (int i = 0; i < 3; i++) begin
      s = {{2{p1_r[3*i][63]}}, p1_r[3*i]} + {{2{p1_r[3*i+1][63]}}, p1_r[3*i+1]} +
          {{2{p1_r[3*i+2][63]}}, p1_r[3*i+2]} + (66'd1 << 29);
      p2_r[i] <= s[65:30];
    end
  end

  out_t out_nxt;

  always_comb begin
    logic [31:0] nx;
    nx = sat32(36'sd0 - $signed({{4{p2_side_r.px[31]}}, p2_side_r.px}));
    if (p2_side_r.pass) begin
      out_nxt = {p2_side_r.px, p2_side_r.py, p2_side_r.pz};
    end else if (p2_side_r.negx) begin
      out_nxt = {nx, p2_side_r.py, p2_side_r.pz};
    end else begin
      out_nxt.result_x = sat32($signed(p2_r[0]));
      out_nxt.result_y = sat32($signed(p2_r[1]));
      out_nxt.result_z = p2_side_r.td ? 32'd0 : sat32($signed(p2_r[2]));
    end
  end

  always_ff @(posedge clk) begin
    out_data <= out_nxt;
  end

  // Valid bits of the stages that live in this module.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t0_v_r    <= 1'b0;
      h_v_r     <= 1'b0;
      x1_v_r    <= 1'b0;
      x2_v_r    <= 1'b0;
      p1_v_r    <= 1'b0;
      p2_v_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      t0_v_r    <= acc;
      h_v_r     <= n1_v;
      x1_v_r    <= n2_v;
      x2_v_r    <= x1_v_r;
      p1_v_r    <= n3_v;
      p2_v_r    <= p1_v_r;
      out_valid <= p2_v_r;
    end
  end

  `OCS_ASSERT_IMPL(a_top_lat, acc, ##PIPE_LAT out_valid, "accepted beat produced no result")
  `OCS_ASSERT_IMPL(a_top_src, out_valid, $past(acc, PIPE_LAT), "result without accepted beat")
  `OCS_ASSERT_IMPL(a_top_planar, out_valid && $past(acc && in_data.two_d, PIPE_LAT),
    out_data.result_z == 32'd0, "planar beat gave non-zero z")

endmodule
